>>> hdl/gowm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gowm_pkg: shared types and constants
// Payload words, pipeline control word, operation codes and register map
// for the orientation weight modulator.
// ----------------------------------------------------------------------------
package gowm_pkg;

	localparam int MAX_CHANNELS_DEF = 4;
	localparam int MAX_TAPS_DEF     = 16;

	// The 2-bit orientation field reaches four channels at most.
	localparam int ORIENT_REACH = 4;

	localparam int OP_W     = 2;
	localparam int ORIENT_W = 2;
	localparam int TAP_IN_W = 4;
	localparam int DATA_W   = 16;
	localparam int COEF_W   = 16;
	localparam int PROD_W   = 32;
	localparam int SUM_W    = 34;
	localparam int CNT_W    = 3;

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_PRODUCE = 2'd1,
		OP_ALIGN   = 2'd2
	} gowm_op_t;

	typedef struct packed {
		gowm_op_t                  operation;
		logic [ORIENT_W-1:0]       orientation;
		logic [TAP_IN_W-1:0]       tap_index;
		logic signed [DATA_W-1:0]  data_value;
	} gowm_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  result_value;
		logic [ORIENT_W-1:0]       result_channel;
		logic                      last_of_run;
	} gowm_result_t;

	// Control word that travels beside the coefficient read.
	typedef struct packed {
		logic                      valid;
		logic                      align;
		logic                      clear;
		logic                      emit;
		logic                      last;
		logic [ORIENT_W-1:0]       channel;
		logic signed [DATA_W-1:0]  data;
	} gowm_ctl_t;

endpackage
`default_nettype wire

>>> hdl/gowm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gowm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gowm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/gowm_issue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gowm_issue: item intake and bank access sequencer
// Takes input words, writes loads into the bank and issues one bank read
// per result step, expanding a produce word over the active channels.
// ----------------------------------------------------------------------------
module gowm_issue #(
	parameter int MAX_CHANNELS = gowm_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_TAPS     = gowm_pkg::MAX_TAPS_DEF,
	localparam int DEPTH  = MAX_CHANNELS * MAX_TAPS,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire gowm_pkg::gowm_item_t            in_word,
	input  wire logic                            advance,
	input  wire logic [gowm_pkg::ORIENT_W-1:0]   last_ch,
	output logic                                 ram_we,
	output logic [ADDR_W-1:0]                    ram_waddr,
	output logic [gowm_pkg::COEF_W-1:0]          ram_wdata,
	output logic                                 ram_re,
	output logic [ADDR_W-1:0]                    ram_raddr,
	output gowm_pkg::gowm_ctl_t                  ctl_s1
);

	localparam int TAP_SPAN = 1 << gowm_pkg::TAP_IN_W;

	logic                               busy_q;
	logic [gowm_pkg::ORIENT_W-1:0]      k_q;
	logic [gowm_pkg::TAP_IN_W-1:0]      tap_q;
	logic signed [gowm_pkg::DATA_W-1:0] data_q;

	logic [TAP_W-1:0] tap_lut [TAP_SPAN];

	logic                               accept;
	logic                               busy_d;
	logic [gowm_pkg::ORIENT_W-1:0]      k_d;
	logic                               hold_item;
	logic [gowm_pkg::ORIENT_W-1:0]      rd_ch;
	logic [gowm_pkg::TAP_IN_W-1:0]      rd_tap;
	gowm_pkg::gowm_ctl_t                ctl_d;

	// Tap reduced modulo the bank row length, worked out at elaboration.
	for (genvar g = 0; g < TAP_SPAN; g++) begin : g_tap_lut
		assign tap_lut[g] = TAP_W'(g % MAX_TAPS);
	end

	function automatic logic [ADDR_W-1:0] bank_addr(
		input logic [gowm_pkg::ORIENT_W-1:0] ch,
		input logic [TAP_W-1:0]              tap_mod
	);
		bank_addr = ADDR_W'(int'(ch) * MAX_TAPS + int'(tap_mod));
	endfunction

	assign in_stall = busy_q || !advance;
	assign accept   = in_valid && !in_stall;

	assign ram_waddr = bank_addr(in_word.orientation, tap_lut[in_word.tap_index]);
	assign ram_wdata = in_word.data_value;
	assign ram_raddr = bank_addr(rd_ch, tap_lut[rd_tap]);

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		busy_d    = busy_q;
		k_d       = k_q;
		hold_item = 1'b0;
		rd_ch     = k_q;
		rd_tap    = tap_q;
		ctl_d     = '0;
		if (busy_q && advance) begin
			// continue a produce run
			ram_re       = 1'b1;
			ctl_d.valid  = 1'b1;
			ctl_d.emit   = 1'b1;
			ctl_d.channel = k_q;
			ctl_d.data   = data_q;
			ctl_d.last   = (k_q == last_ch);
			if (k_q == last_ch) begin
				busy_d = 1'b0;
			end else begin
				k_d = k_q + 1'b1;
			end
		end else if (accept) begin
			rd_tap = in_word.tap_index;
			case (in_word.operation)
				gowm_pkg::OP_LOAD: begin
					ram_we = (int'(in_word.orientation) < MAX_CHANNELS);
				end
				gowm_pkg::OP_PRODUCE: begin
					rd_ch       = '0;
					ram_re      = 1'b1;
					ctl_d.valid = 1'b1;
					ctl_d.emit  = 1'b1;
					ctl_d.data  = in_word.data_value;
					ctl_d.last  = (last_ch == '0);
					hold_item   = 1'b1;
					if (last_ch != '0) begin
						busy_d = 1'b1;
						k_d    = gowm_pkg::ORIENT_W'(1);
					end
				end
				gowm_pkg::OP_ALIGN: begin
					rd_ch = in_word.orientation;
					if (in_word.orientation <= last_ch) begin
						ram_re      = 1'b1;
						ctl_d.valid = 1'b1;
						ctl_d.align = 1'b1;
						ctl_d.clear = (in_word.orientation == '0);
						ctl_d.emit  = (in_word.orientation == last_ch);
						ctl_d.last  = 1'b1;
						ctl_d.data  = in_word.data_value;
					end
				end
				default: begin
					// unused operation code: drop
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			ctl_s1 <= '0;
		end else if (advance) begin
			busy_q <= busy_d;
			k_q    <= k_d;
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_item) begin
			tap_q  <= in_word.tap_index;
			data_q <= in_word.data_value;
		end
	end

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !advance |=> busy_q && $stable(k_q))
		else $error("produce run lost its place while blocked");

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("bank read and write issued together");

	a_align_single: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && ctl_s1.align |-> ctl_s1.last && (ctl_s1.channel == '0))
		else $error("align step carries a bad marker");

endmodule
`default_nettype wire

>>> hdl/gowm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gowm_datapath: multiply, accumulate and output stage
// Multiplies the word by the bank coefficient, updates the gradient sum,
// rounds Q7.26 to saturated Q3.12 and holds the result word.
// ----------------------------------------------------------------------------
module gowm_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire gowm_pkg::gowm_ctl_t             ctl_s1,
	input  wire logic [gowm_pkg::COEF_W-1:0]     coef_s1,
	output logic                                 advance,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output gowm_pkg::gowm_result_t               out_word
);

	localparam int SUM_W  = gowm_pkg::SUM_W;
	localparam int PROD_W = gowm_pkg::PROD_W;
	localparam int RND_W  = SUM_W + 1;
	localparam int Q_W    = RND_W - 14;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
	localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

	gowm_pkg::gowm_ctl_t         ctl_s2;
	logic signed [PROD_W-1:0]    prod_s2;
	gowm_pkg::gowm_ctl_t         ctl_s3;
	logic signed [SUM_W-1:0]     val_s3;
	logic signed [SUM_W-1:0]     sum_q;
	logic                        out_valid_q;
	gowm_pkg::gowm_result_t      out_q;

	logic signed [SUM_W-1:0]     sum_base;
	logic signed [RND_W-1:0]     sum_raw;
	logic signed [SUM_W-1:0]     sum_next;
	logic signed [RND_W-1:0]     rnd;
	logic signed [Q_W-1:0]       q;
	logic signed [gowm_pkg::DATA_W-1:0] q_sat;

	assign advance   = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// Accumulate with saturation to the 34-bit range.
	always_comb begin
		sum_base = ctl_s2.clear ? '0 : sum_q;
		sum_raw  = RND_W'(sum_base) + RND_W'(prod_s2);
		if (sum_raw[RND_W-1] != sum_raw[RND_W-2]) begin
			sum_next = sum_raw[RND_W-1] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_raw[SUM_W-1:0];
		end
	end

	// Round half up, drop 14 fraction bits, saturate to 16 bits.
	always_comb begin
		rnd = RND_W'(val_s3) + RND_W'(8192);
		q   = rnd[RND_W-1:14];
		if (q > Q_MAX) begin
			q_sat = Q_MAX[gowm_pkg::DATA_W-1:0];
		end else if (q < Q_MIN) begin
			q_sat = Q_MIN[gowm_pkg::DATA_W-1:0];
		end else begin
			q_sat = q[gowm_pkg::DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			out_valid_q <= ctl_s3.valid && ctl_s3.emit;
			if (ctl_s2.valid && ctl_s2.align) begin
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= ctl_s1.data * $signed(coef_s1);
			val_s3  <= ctl_s2.align ? sum_next : SUM_W'(prod_s2);
			out_q.result_value   <= q_sat;
			out_q.result_channel <= ctl_s3.channel;
			out_q.last_of_run    <= ctl_s3.last;
		end
	end

	a_sum_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(sum_q) && $stable(ctl_s3))
		else $error("pipeline moved while the result word was blocked");

endmodule
`default_nettype wire

>>> hdl/gabor_orientation_weight_modulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gabor_orientation_weight_modulator: Gabor coefficient bank and modulator
// Top level: configuration register, coefficient bank, issue sequencer and
// arithmetic pipeline.
// ----------------------------------------------------------------------------
// The block keeps a bank of Q1.14 Gabor coefficients, one per orientation
// channel and kernel tap, in a single-port-read synchronous RAM. A load word
// writes one coefficient. A produce word reads the tap's coefficient for
// every active channel, one bank read per cycle unless the result side
// stalls, and returns one Q3.12 result word per channel in order from channel
// 0, the last one marked; it holds the input off until all active channels
// (1 to 4) are read, since the bank offers one read per cycle. An align word
// multiplies its gradient by one coefficient and adds the product into a
// 34-bit saturating Q7.26 sum that restarts on channel 0; the rounded sum
// comes out after the last active channel. Results pass the s1, s2 and s3
// stage registers to the result register; back-pressure on the result side
// freezes the whole pipeline. The bank has no reset and no clearing pass:
// write an entry before it is read. channel_count sits at byte address 0 of
// the configuration port; 0 behaves as 1, and values above the channel limit
// are capped. Change it only while the block is idle.
// ----------------------------------------------------------------------------
module gabor_orientation_weight_modulator #(
	parameter int MAX_CHANNELS = gowm_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_TAPS     = gowm_pkg::MAX_TAPS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// item channel
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire gowm_pkg::gowm_item_t            item,
	// result channel
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output gowm_pkg::gowm_result_t               result,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [gowm_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [gowm_pkg::PDATA_W-1:0]    pwdata,
	output logic [gowm_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);

	localparam int DEPTH  = MAX_CHANNELS * MAX_TAPS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_CAP = (MAX_CHANNELS < gowm_pkg::ORIENT_REACH) ?
		MAX_CHANNELS : gowm_pkg::ORIENT_REACH;

	logic [gowm_pkg::CNT_W-1:0]          channel_count_q;
	logic [gowm_pkg::CNT_W-1:0]          n_active;
	logic [gowm_pkg::ORIENT_W-1:0]       last_ch;
	logic [gowm_pkg::REG_IDX_W-1:0]      reg_idx;
	logic                                cfg_write;

	logic                                advance;
	logic                                ram_we;
	logic [ADDR_W-1:0]                   ram_waddr;
	logic [gowm_pkg::COEF_W-1:0]         ram_wdata;
	logic                                ram_re;
	logic [ADDR_W-1:0]                   ram_raddr;
	logic [gowm_pkg::COEF_W-1:0]         coef_s1;
	gowm_pkg::gowm_ctl_t                 ctl_s1;

	// Configuration: one register, word aligned, no wait states.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[gowm_pkg::PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (reg_idx == gowm_pkg::REG_CHANNEL_COUNT) begin
			prdata = gowm_pkg::PDATA_W'(channel_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= gowm_pkg::CHANNEL_COUNT_RST;
		end else if (cfg_write && reg_idx == gowm_pkg::REG_CHANNEL_COUNT) begin
			channel_count_q <= pwdata[gowm_pkg::CNT_W-1:0];
		end
	end

	// Effective channel count: zero means one, cap at the channel limit.
	always_comb begin
		n_active = channel_count_q;
		if (channel_count_q == '0) begin
			n_active = gowm_pkg::CNT_W'(1);
		end
		if (int'(n_active) > CH_CAP) begin
			n_active = gowm_pkg::CNT_W'(CH_CAP);
		end
	end

	assign last_ch = gowm_pkg::ORIENT_W'(n_active - 1'b1);

	gowm_issue #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_TAPS     (MAX_TAPS)
	) u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_stall  (item_stall),
		.in_word   (item),
		.advance   (advance),
		.last_ch   (last_ch),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ctl_s1    (ctl_s1)
	);

	// Coefficient bank, entry = channel * MAX_TAPS + (tap mod MAX_TAPS).
	gowm_ram #(
		.WIDTH (gowm_pkg::COEF_W),
		.DEPTH (DEPTH)
	) u_bank (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (coef_s1)
	);

	gowm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.coef_s1   (coef_s1),
		.advance   (advance),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_word  (result)
	);

endmodule
`default_nettype wire
